// ===== hdl/tccs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console package
// Item and result types, codes and the sequencer control store of the text
// console.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int SCREEN_COLS_DEF = 80;
  localparam int SCREEN_ROWS_DEF = 25;
  localparam int CELL_W          = 16;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_SET   = 2'd2,
    ACT_READ  = 2'd3
  } act_t;

  typedef struct packed {
    act_t       action;
    logic [7:0] char_code;
    logic [4:0] target_row;
    logic [6:0] target_col;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cursor_row_now;
    logic [6:0] cursor_col_now;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;
  } out_item_t;

  typedef enum logic [2:0] {
    RAM_NONE    = 3'd0,
    RAM_WR_PUT  = 3'd1,
    RAM_RD_TGT  = 3'd2,
    RAM_RD_COPY = 3'd3,
    RAM_WR_COPY = 3'd4,
    RAM_WR_FILL = 3'd5
  } ram_op_t;

  typedef enum logic [1:0] {
    ADDR_HOLD = 2'd0,
    ADDR_ZERO = 2'd1,
    ADDR_INC  = 2'd2
  } addr_op_t;

  typedef enum logic [1:0] {
    CUR_HOLD    = 2'd0,
    CUR_ADVANCE = 2'd1,
    CUR_HOME    = 2'd2,
    CUR_SET     = 2'd3
  } cur_op_t;

  typedef enum logic [2:0] {
    JC_NONE      = 3'd0,
    JC_OVF       = 3'd1,
    JC_COPY_END  = 3'd2,
    JC_FILL_END  = 3'd3,
    JC_SLOT_BUSY = 3'd4
  } jcond_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_PUT    = 4'd1,
    ST_SCR_RD = 4'd2,
    ST_SCR_WR = 4'd3,
    ST_FILL   = 4'd4,
    ST_CLR    = 4'd5,
    ST_SET    = 4'd6,
    ST_READ   = 4'd7,
    ST_DONE   = 4'd8
  } step_t;

  typedef struct packed {
    ram_op_t  ram_op;
    addr_op_t addr_op;
    cur_op_t  cur_op;
    logic     fill_load;
    logic     take_item;
    logic     emit;
    jcond_t   jcond;
    step_t    jump_to;
    step_t    next_step;
  } ucw_t;

  typedef struct packed {
    logic accept;
    act_t action;
    logic ovf;
    logic copy_end;
    logic fill_end;
    logic slot_busy;
  } seq_stat_t;

  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    w = '0;
    w.next_step = ST_IDLE;
    w.jump_to   = ST_IDLE;
    unique case (s)
      ST_IDLE: begin
        w.take_item = 1'b1;
      end
      ST_PUT: begin
        w.ram_op    = RAM_WR_PUT;
        w.cur_op    = CUR_ADVANCE;
        w.addr_op   = ADDR_ZERO;
        w.fill_load = 1'b1;
        w.jcond     = JC_OVF;
        w.jump_to   = ST_SCR_RD;
        w.next_step = ST_DONE;
      end
      ST_SCR_RD: begin
        w.ram_op    = RAM_RD_COPY;
        w.next_step = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        w.ram_op    = RAM_WR_COPY;
        w.addr_op   = ADDR_INC;
        w.jcond     = JC_COPY_END;
        w.jump_to   = ST_FILL;
        w.next_step = ST_SCR_RD;
      end
      ST_FILL: begin
        w.ram_op    = RAM_WR_FILL;
        w.addr_op   = ADDR_INC;
        w.jcond     = JC_FILL_END;
        w.jump_to   = ST_DONE;
        w.next_step = ST_FILL;
      end
      ST_CLR: begin
        w.fill_load = 1'b1;
        w.addr_op   = ADDR_ZERO;
        w.cur_op    = CUR_HOME;
        w.next_step = ST_FILL;
      end
      ST_SET: begin
        w.cur_op    = CUR_SET;
        w.next_step = ST_DONE;
      end
      ST_READ: begin
        w.ram_op    = RAM_RD_TGT;
        w.next_step = ST_DONE;
      end
      ST_DONE: begin
        w.take_item = 1'b1;
        w.emit      = 1'b1;
        w.jcond     = JC_SLOT_BUSY;
        w.jump_to   = ST_DONE;
      end
      default: begin
        w.next_step = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/text_console_cursor_scroll_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console with cursor and scroll
// Character cell store with a cursor, driven by put, clear, set-cursor and
// read-cell items, one result per item.
// ----------------------------------------------------------------------------
// Put, set-cursor and read-cell items each pass through their own step and the
// done step, and the next item is accepted in the cycle in which the previous
// result is registered, while the output slot is free. All cell traffic goes
// through one single-port-write, single-port-read memory of
// SCREEN_ROWS*SCREEN_COLS cells, and that port sets the cost of the long
// actions: a put that scrolls copies every cell below the top row up one row,
// a read and then a write per cell, then blanks the last row, and a clear
// blanks every cell. After reset the block blanks the store with in_ready low;
// configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top #(
  parameter int SCREEN_COLS = tccs_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = tccs_pkg::SCREEN_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tccs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tccs_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(SCREEN_ROWS);
  localparam int COL_W      = $clog2(SCREEN_COLS);

  tccs_pkg::ucw_t      cw;
  tccs_pkg::seq_stat_t stat;

  tccs_pkg::in_item_t  item_r;
  tccs_pkg::out_item_t out_r;
  logic                out_valid_r;
  logic                init_r;
  logic [7:0]          default_attr_r;
  logic [7:0]          fill_attr_r;
  logic                scrolled_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [ADDR_W-1:0]   addr_nxt;
  logic [ROW_W-1:0]    cur_row_r;
  logic [ROW_W-1:0]    cur_row_nxt;
  logic [COL_W-1:0]    cur_col_r;
  logic [COL_W-1:0]    cur_col_nxt;

  logic                accept;
  logic                slot_busy;
  logic                emit_now;
  logic                is_nl;
  logic                row_last;
  logic                col_last;
  logic                ovf;
  logic [ROW_W-1:0]    tgt_row;
  logic [COL_W-1:0]    tgt_col;
  logic [ADDR_W-1:0]   cur_idx;
  logic [ADDR_W-1:0]   tgt_idx;
  logic [31:0]         row_ext;
  logic [31:0]         col_ext;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [tccs_pkg::CELL_W-1:0] ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [tccs_pkg::CELL_W-1:0] ram_rdata;

  assign slot_busy = out_valid_r && !out_ready;
  assign in_ready  = cw.take_item && !(cw.emit && slot_busy);
  assign accept    = in_valid && in_ready;
  assign emit_now  = cw.emit && !slot_busy;

  assign is_nl    = (item_r.char_code == tccs_pkg::NEWLINE_CODE);
  assign row_last = (cur_row_r == ROW_W'(SCREEN_ROWS - 1));
  assign col_last = (cur_col_r == COL_W'(SCREEN_COLS - 1));
  assign ovf      = (is_nl || col_last) && row_last;

  always_comb begin
    if (32'(item_r.target_row) >= 32'(SCREEN_ROWS)) begin
      tgt_row = ROW_W'(SCREEN_ROWS - 1);
    end else begin
      tgt_row = ROW_W'(item_r.target_row);
    end
    if (32'(item_r.target_col) >= 32'(SCREEN_COLS)) begin
      tgt_col = COL_W'(SCREEN_COLS - 1);
    end else begin
      tgt_col = COL_W'(item_r.target_col);
    end
  end

  assign cur_idx = ADDR_W'(cur_row_r) * ADDR_W'(SCREEN_COLS) + ADDR_W'(cur_col_r);
  assign tgt_idx = ADDR_W'(tgt_row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(tgt_col);

  always_comb begin
    stat.accept    = accept;
    stat.action    = in_data.action;
    stat.ovf       = ovf;
    stat.copy_end  = (addr_r == ADDR_W'(CELL_COUNT - SCREEN_COLS - 1));
    stat.fill_end  = (addr_r == ADDR_W'(CELL_COUNT - 1));
    stat.slot_busy = slot_busy;
  end

  tccs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cw    (cw)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = {fill_attr_r, tccs_pkg::BLANK_CODE};
    ram_re    = 1'b0;
    ram_raddr = tgt_idx;
    unique case (cw.ram_op)
      tccs_pkg::RAM_NONE: begin
      end
      tccs_pkg::RAM_WR_PUT: begin
        ram_we    = !is_nl;
        ram_waddr = cur_idx;
        ram_wdata = {default_attr_r, item_r.char_code};
      end
      tccs_pkg::RAM_RD_TGT: begin
        ram_re = 1'b1;
      end
      tccs_pkg::RAM_RD_COPY: begin
        ram_re    = 1'b1;
        ram_raddr = addr_r + ADDR_W'(SCREEN_COLS);
      end
      tccs_pkg::RAM_WR_COPY: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      tccs_pkg::RAM_WR_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tccs_ram #(
    .WIDTH (tccs_pkg::CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    unique case (cw.addr_op)
      tccs_pkg::ADDR_HOLD: addr_nxt = addr_r;
      tccs_pkg::ADDR_ZERO: addr_nxt = '0;
      tccs_pkg::ADDR_INC:  addr_nxt = addr_r + ADDR_W'(1);
      default:             addr_nxt = addr_r;
    endcase
  end

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    unique case (cw.cur_op)
      tccs_pkg::CUR_HOLD: begin
      end
      tccs_pkg::CUR_ADVANCE: begin
        if (is_nl || col_last) begin
          cur_col_nxt = '0;
          if (!row_last) begin
            cur_row_nxt = cur_row_r + ROW_W'(1);
          end
        end else begin
          cur_col_nxt = cur_col_r + COL_W'(1);
        end
      end
      tccs_pkg::CUR_HOME: begin
        cur_row_nxt = '0;
        cur_col_nxt = '0;
      end
      tccs_pkg::CUR_SET: begin
        cur_row_nxt = tgt_row;
        cur_col_nxt = tgt_col;
      end
      default: begin
      end
    endcase
  end

  assign row_ext = 32'(cur_row_r);
  assign col_ext = 32'(cur_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r         <= '0;
      cur_row_r      <= '0;
      cur_col_r      <= '0;
      default_attr_r <= tccs_pkg::RESET_ATTR;
      fill_attr_r    <= tccs_pkg::RESET_ATTR;
      init_r         <= 1'b1;
      out_valid_r    <= 1'b0;
      scrolled_r     <= 1'b0;
    end else begin
      addr_r    <= addr_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      if (cfg_we) begin
        default_attr_r <= cfg_wdata;
      end
      if (cw.fill_load) begin
        fill_attr_r <= default_attr_r;
      end
      if (emit_now) begin
        init_r <= 1'b0;
      end
      if (emit_now && !init_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        scrolled_r <= 1'b0;
      end else if (cw.cur_op == tccs_pkg::CUR_ADVANCE && ovf) begin
        scrolled_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (emit_now && !init_r) begin
      out_r.cursor_row_now <= row_ext[4:0];
      out_r.cursor_col_now <= col_ext[6:0];
      out_r.scrolled       <= scrolled_r;
      if (item_r.action == tccs_pkg::ACT_READ) begin
        out_r.cell_char <= ram_rdata[7:0];
        out_r.cell_attr <= ram_rdata[15:8];
      end else begin
        out_r.cell_char <= '0;
        out_r.cell_attr <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/tccs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tccs_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console sequencer
// Step counter over the control store, with item dispatch and conditional
// jumps.
// ----------------------------------------------------------------------------
module tccs_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  tccs_pkg::seq_stat_t stat,
  output tccs_pkg::ucw_t      cw
);

  tccs_pkg::step_t step_r;
  tccs_pkg::step_t step_nxt;
  logic            cond_true;

  always_comb begin
    cw = tccs_pkg::ucode(step_r);
  end

  always_comb begin
    unique case (cw.jcond)
      tccs_pkg::JC_NONE:      cond_true = 1'b0;
      tccs_pkg::JC_OVF:       cond_true = stat.ovf;
      tccs_pkg::JC_COPY_END:  cond_true = stat.copy_end;
      tccs_pkg::JC_FILL_END:  cond_true = stat.fill_end;
      tccs_pkg::JC_SLOT_BUSY: cond_true = stat.slot_busy;
      default:                cond_true = 1'b0;
    endcase
  end

  always_comb begin
    priority if (stat.accept) begin
      unique case (stat.action)
        tccs_pkg::ACT_PUT:   step_nxt = tccs_pkg::ST_PUT;
        tccs_pkg::ACT_CLEAR: step_nxt = tccs_pkg::ST_CLR;
        tccs_pkg::ACT_SET:   step_nxt = tccs_pkg::ST_SET;
        tccs_pkg::ACT_READ:  step_nxt = tccs_pkg::ST_READ;
        default:             step_nxt = tccs_pkg::ST_IDLE;
      endcase
    end else if (cond_true) begin
      step_nxt = cw.jump_to;
    end else begin
      step_nxt = cw.next_step;
    end
  end

  // After reset the sequencer starts in the fill loop to blank the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= tccs_pkg::ST_FILL;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
